>>> rtl/core/voxel_face_cull_light_mesher_macros.svh
// Assertion macros of the checker file of the voxel mesher.
`ifndef VOXEL_FACE_CULL_LIGHT_MESHER_MACROS_SVH
`define VOXEL_FACE_CULL_LIGHT_MESHER_MACROS_SVH

// Checks a consequent in the same cycle as its antecedent.
`define VFCL_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("voxel mesher assertion failed");

// Checks a consequent in the cycle after its antecedent.
`define VFCL_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("voxel mesher assertion failed");

`endif

>>> rtl/core/vfcl_pkg.sv
// Types, constants and tables of the voxel face mesher.
`timescale 1ns / 1ps
`default_nettype none
package vfcl_pkg;

   localparam int CHUNK_EDGE_DEF = 16;
   localparam int TILE_SIZE_DEF  = 16;
   localparam int ATLAS_SIZE_DEF = 512;

   localparam int COORD_W = 5;
   localparam int CW      = COORD_W + 1;
   localparam int TYPE_W  = 4;
   localparam int LIGHT_W = 8;
   localparam int CELL_W  = TYPE_W + LIGHT_W;
   localparam int FACE_W  = 3;
   localparam int TEX_W   = 9;
   localparam int POS_W   = 4;
   localparam int SUM_W   = LIGHT_W + 2;
   localparam int NUM_W   = 20;
   localparam int DEN_W   = 12;
   localparam int NUM_FACES = 6;
   localparam int NUM_CORNERS = 4;
   localparam int GRID_N  = 9;
   localparam int QUEUE_DEPTH = 2;
   localparam int SCALE_STEPS = 8;

   localparam logic [TYPE_W-1:0]  TYPE_AIR     = 4'd0;
   localparam logic [TYPE_W-1:0]  TYPE_EMITTER = 4'd4;
   localparam logic [LIGHT_W-1:0] LIGHT_FULL   = 8'd255;

   localparam logic [0:0] CSR_MIN_LIGHT = 1'b0;
   localparam logic [0:0] CSR_MAX_LIGHT = 1'b1;

   localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd0;
   localparam logic [FACE_W-1:0] FACE_BACK   = 3'd1;
   localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd2;
   localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd3;
   localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd4;
   localparam logic [FACE_W-1:0] FACE_TOP    = 3'd5;
   localparam logic [FACE_W-1:0] FACE_END    = 3'd6;

   typedef struct packed {
      logic                mesh;
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  y;
      logic [COORD_W-1:0]  z;
      logic [TYPE_W-1:0]   btype;
      logic [LIGHT_W-1:0]  light;
   } vfcl_cmd_type;

   typedef struct packed {
      logic                                start;
      logic [NUM_CORNERS-1:0][SUM_W-1:0]   sum4;
      logic [LIGHT_W-1:0]                  nl;
   } vfcl_scale_req_type;

   typedef struct packed {
      logic                                done;
      logic [NUM_CORNERS-1:0][LIGHT_W-1:0] lit;
   } vfcl_scale_rsp_type;

   typedef enum logic [3:0] {
      B_IDLE, B_OWN, B_MASK, B_MASKW, B_FSEL, B_GRID, B_GWAIT, B_SGO, B_SWAIT, B_EMIT
   } vfcl_back_state_type;

   function automatic logic [TYPE_W-1:0] tile_index(input logic [TYPE_W-1:0] btype,
                                                    input logic [FACE_W-1:0] face);
      logic [TYPE_W-1:0] idx;
      idx = 4'd0;
      unique case (btype)
         4'd1: idx = 4'd2;
         4'd2: idx = 4'd3;
         4'd3: idx = (face == FACE_BOTTOM) ? 4'd2 : ((face == FACE_TOP) ? 4'd1 : 4'd0);
         4'd4: idx = 4'd4;
         4'd5: idx = 4'd5;
         4'd6: idx = (face == FACE_BOTTOM || face == FACE_TOP) ? 4'd7 : 4'd6;
         4'd7: idx = 4'd8;
         4'd8: idx = 4'd9;
         default: idx = 4'd0;
      endcase
      return idx;
   endfunction

   // Two bits per corner, corner k at [2k+1:2k]: negative step along the first
   // and the second in-plane axis of the face.
   function automatic logic [2*NUM_CORNERS-1:0] corner_code(input logic [FACE_W-1:0] face);
      logic [2*NUM_CORNERS-1:0] code;
      code = 8'b0;
      unique case (face)
         FACE_FRONT:  code = {2'b00, 2'b10, 2'b11, 2'b01};
         FACE_BACK:   code = {2'b01, 2'b11, 2'b10, 2'b00};
         FACE_RIGHT:  code = {2'b01, 2'b11, 2'b10, 2'b00};
         FACE_LEFT:   code = {2'b00, 2'b10, 2'b11, 2'b01};
         FACE_BOTTOM: code = {2'b01, 2'b11, 2'b10, 2'b00};
         FACE_TOP:    code = {2'b11, 2'b01, 2'b00, 2'b10};
         default:     code = 8'b0;
      endcase
      return code;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/vfcl_if.sv
// Valid and ready channel interfaces for requests and face records.
`timescale 1ns / 1ps
`default_nettype none
interface vfcl_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [4:0] cell_x;
   logic [4:0] cell_y;
   logic [4:0] cell_z;
   logic [3:0] block_type;
   logic [7:0] light_level;

   modport source(output valid, func, cell_x, cell_y, cell_z, block_type, light_level,
                  input ready);
   modport sink(input valid, func, cell_x, cell_y, cell_z, block_type, light_level,
                output ready);
endinterface

interface vfcl_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] pos_x;
   logic [3:0] pos_y;
   logic [3:0] pos_z;
   logic [2:0] face;
   logic [8:0] tex_x;
   logic [8:0] tex_y;
   logic [7:0] corner_a;
   logic [7:0] corner_b;
   logic [7:0] corner_c;
   logic [7:0] corner_d;
   logic [7:0] centre_light;
   logic       last_face;

   modport source(output valid, pos_x, pos_y, pos_z, face, tex_x, tex_y, corner_a,
                  corner_b, corner_c, corner_d, centre_light, last_face, input ready);
   modport sink(input valid, pos_x, pos_y, pos_z, face, tex_x, tex_y, corner_a,
                corner_b, corner_c, corner_d, centre_light, last_face, output ready);
endinterface
`default_nettype wire

>>> rtl/core/vfcl_front.sv
// Request intake: classifies items and queues the ones that need work.
`timescale 1ns / 1ps
`default_nettype none
module vfcl_front
   import vfcl_pkg::*;
#(
   parameter int CHUNK_EDGE = CHUNK_EDGE_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   vfcl_req_if.sink    req,
   output logic        cmd_valid,
   output vfcl_cmd_type cmd,
   input  wire logic   cmd_ready
);

   localparam int PAD   = CHUNK_EDGE + 2;
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   vfcl_cmd_type       fifo_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               in_pad, interior, keep, push, pop;

   always_comb begin
      in_pad   = (int'(req.cell_x) < PAD) && (int'(req.cell_y) < PAD) &&
                 (int'(req.cell_z) < PAD);
      interior = (req.cell_x != '0) && (req.cell_y != '0) && (req.cell_z != '0) &&
                 (int'(req.cell_x) <= CHUNK_EDGE) && (int'(req.cell_y) <= CHUNK_EDGE) &&
                 (int'(req.cell_z) <= CHUNK_EDGE);
      keep     = req.func ? interior : in_pad;
      push     = req.valid && req.ready && keep;
      pop      = cmd_valid && cmd_ready;
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   assign req.ready = (int'(count_ff) != QUEUE_DEPTH);
   assign cmd_valid = (count_ff != '0);
   assign cmd       = fifo_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= '{mesh: req.func, x: req.cell_x, y: req.cell_y,
                                 z: req.cell_z, btype: req.block_type,
                                 light: req.light_level};
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/vfcl_scale.sv
// Corner light scaling: four divider lanes, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module vfcl_scale
   import vfcl_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire vfcl_scale_req_type sreq,
   input  wire logic [LIGHT_W-1:0] min_light,
   input  wire logic [LIGHT_W-1:0] max_light,
   output vfcl_scale_rsp_type      srsp
);

   localparam int STEP_W = $clog2(SCALE_STEPS + 1);

   logic [NUM_W-1:0]   rem_ff [NUM_CORNERS];
   logic [LIGHT_W-1:0] quo_ff [NUM_CORNERS];
   logic               sat_ff [NUM_CORNERS];
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [STEP_W-1:0]  step_ff;
   logic               busy_ff, done_ff;
   logic [NUM_W-1:0]   num_in [NUM_CORNERS];
   logic [NUM_W-1:0]   num_b, num_c, trial;
   logic [LIGHT_W-1:0] m_eff;

   // All three terms share the denominator 12 * max_light, so the largest
   // numerator gives the largest quotient.
   always_comb begin
      m_eff  = (max_light == '0) ? 8'd1 : max_light;
      den_in = DEN_W'(DEN_W'(m_eff) * DEN_W'(12));
      num_b  = NUM_W'(NUM_W'(sreq.nl) * NUM_W'(1020));
      num_c  = NUM_W'(NUM_W'(min_light) * NUM_W'(3060));
      for (int k = 0; k < NUM_CORNERS; k++) begin
         num_in[k] = NUM_W'(NUM_W'(sreq.sum4[k]) * NUM_W'(765));
         if (num_b > num_in[k]) num_in[k] = num_b;
         if (num_c > num_in[k]) num_in[k] = num_c;
      end
      trial = NUM_W'(den_ff) << step_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (sreq.start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(SCALE_STEPS);
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sreq.start) begin
         den_ff <= den_in;
         for (int k = 0; k < NUM_CORNERS; k++) begin
            rem_ff[k] <= num_in[k];
            quo_ff[k] <= '0;
            sat_ff[k] <= 1'b0;
         end
      end else if (busy_ff) begin
         for (int k = 0; k < NUM_CORNERS; k++) begin
            if (int'(step_ff) == SCALE_STEPS) begin
               sat_ff[k] <= (rem_ff[k] >= trial);
            end else if (rem_ff[k] >= trial) begin
               rem_ff[k] <= rem_ff[k] - trial;
               quo_ff[k][step_ff[2:0]] <= 1'b1;
            end
         end
      end
   end

   always_comb begin
      srsp.done = done_ff;
      for (int k = 0; k < NUM_CORNERS; k++) begin
         srsp.lit[k] = sat_ff[k] ? LIGHT_FULL : quo_ff[k];
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/vfcl_back.sv
// Command execution: volume memory, neighbour sequencer and face record output.
`timescale 1ns / 1ps
`default_nettype none
module vfcl_back
   import vfcl_pkg::*;
#(
   parameter int CHUNK_EDGE = CHUNK_EDGE_DEF,
   parameter int TILE_SIZE  = TILE_SIZE_DEF,
   parameter int ATLAS_SIZE = ATLAS_SIZE_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               cmd_valid,
   input  wire vfcl_cmd_type       cmd,
   output logic                    cmd_ready,
   input  wire logic [LIGHT_W-1:0] min_light,
   input  wire logic [LIGHT_W-1:0] max_light,
   vfcl_rsp_if.source              rsp
);

   localparam int PAD     = CHUNK_EDGE + 2;
   localparam int DEPTH   = PAD * PAD * PAD;
   localparam int AW      = $clog2(DEPTH);
   localparam int TPR_RAW = ATLAS_SIZE / TILE_SIZE;
   localparam int TPR     = (TPR_RAW == 0) ? 1 : TPR_RAW;
   localparam int TEX_MOD = 2 ** TEX_W;
   localparam int TILES   = 2 ** TYPE_W;

   logic [CELL_W-1:0]  mem [DEPTH];
   logic [CELL_W-1:0]  rd_data_ff;

   vfcl_back_state_type state_ff, state_in;
   logic [COORD_W-1:0] cx_ff, cy_ff, cz_ff;
   logic [TYPE_W-1:0]  type_ff;
   logic [NUM_FACES-1:0] mask_ff;
   logic [FACE_W-1:0]  face_ff, face_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic [1:0]         pi_ff, pi_in, qi_ff, qi_in;
   logic               rd_live_ff, rd_grid_ff;
   logic [3:0]         rd_tag_ff;
   logic [LIGHT_W-1:0] grid_ff [GRID_N];

   logic               rsp_valid_ff;
   logic [POS_W-1:0]   pos_x_ff, pos_y_ff, pos_z_ff;
   logic [FACE_W-1:0]  face_out_ff;
   logic [TEX_W-1:0]   tex_x_ff, tex_y_ff;
   logic [LIGHT_W-1:0] lit_ff [NUM_CORNERS];
   logic [LIGHT_W-1:0] centre_ff;
   logic               last_ff;

   logic               issue_live, issue_grid, latch_cell, latch_type, emit_load, mem_we;
   logic               scale_start;
   logic [3:0]         issue_tag;
   logic [FACE_W-1:0]  sel_face;
   logic [1:0]         sel_pi, sel_qi;
   logic [CW-1:0]      rd_x, rd_y, rd_z;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic               slot_free;
   logic [NUM_FACES-1:0] above_mask;
   logic [2*NUM_CORNERS-1:0] ccode;
   logic [LIGHT_W-1:0] lit_sel [NUM_CORNERS];
   logic [SUM_W-1:0]   lit_sum;
   logic [TYPE_W-1:0]  tile;
   logic [TEX_W-1:0]   tex_x_tbl [TILES];
   logic [TEX_W-1:0]   tex_y_tbl [TILES];
   vfcl_scale_req_type sreq;
   vfcl_scale_rsp_type srsp;

   for (genvar gi = 0; gi < TILES; gi++) begin : g_tex
      localparam int TX = ((gi % TPR) * TILE_SIZE) % TEX_MOD;
      localparam int TY = ((gi / TPR) * TILE_SIZE) % TEX_MOD;
      assign tex_x_tbl[gi] = TEX_W'(TX);
      assign tex_y_tbl[gi] = TEX_W'(TY);
   end

   function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x,
                                                input logic [CW-1:0] y,
                                                input logic [CW-1:0] z);
      return AW'((AW'(x) * AW'(PAD) + AW'(y)) * AW'(PAD) + AW'(z));
   endfunction

   vfcl_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .sreq      (sreq),
      .min_light (min_light),
      .max_light (max_light),
      .srsp      (srsp)
   );

   assign slot_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in    = state_ff;
      face_in     = face_ff;
      cnt_in      = cnt_ff;
      pi_in       = pi_ff;
      qi_in       = qi_ff;
      issue_live  = 1'b0;
      issue_grid  = 1'b0;
      issue_tag   = cnt_ff;
      sel_face    = face_ff;
      sel_pi      = 2'd1;
      sel_qi      = 2'd1;
      latch_cell  = 1'b0;
      latch_type  = 1'b0;
      emit_load   = 1'b0;
      mem_we      = 1'b0;
      cmd_ready   = 1'b0;
      scale_start = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               if (cmd.mesh) begin
                  latch_cell = 1'b1;
                  state_in   = B_OWN;
               end else begin
                  mem_we = 1'b1;
               end
            end
         end
         B_OWN: begin
            latch_type = 1'b1;
            if (rd_data_ff[CELL_W-1:LIGHT_W] == TYPE_AIR) begin
               state_in = B_IDLE;
            end else begin
               sel_face   = FACE_FRONT;
               issue_live = 1'b1;
               issue_tag  = 4'd0;
               cnt_in     = 4'd1;
               state_in   = B_MASK;
            end
         end
         B_MASK: begin
            sel_face   = cnt_ff[FACE_W-1:0];
            issue_live = 1'b1;
            cnt_in     = cnt_ff + 4'd1;
            if (cnt_ff == 4'(FACE_TOP)) state_in = B_MASKW;
         end
         B_MASKW: begin
            face_in  = FACE_FRONT;
            state_in = B_FSEL;
         end
         B_FSEL: begin
            if (face_ff == FACE_END) begin
               state_in = B_IDLE;
            end else if (mask_ff[face_ff]) begin
               cnt_in   = 4'd0;
               pi_in    = 2'd0;
               qi_in    = 2'd0;
               state_in = (type_ff == TYPE_EMITTER) ? B_EMIT : B_GRID;
            end else begin
               face_in = face_ff + 1'b1;
            end
         end
         B_GRID: begin
            sel_pi     = pi_ff;
            sel_qi     = qi_ff;
            issue_live = 1'b1;
            issue_grid = 1'b1;
            cnt_in     = cnt_ff + 4'd1;
            if (qi_ff == 2'd2) begin
               qi_in = 2'd0;
               pi_in = pi_ff + 2'd1;
            end else begin
               qi_in = qi_ff + 2'd1;
            end
            if (int'(cnt_ff) == GRID_N - 1) state_in = B_GWAIT;
         end
         B_GWAIT: state_in = B_SGO;
         B_SGO: begin
            scale_start = 1'b1;
            state_in    = B_SWAIT;
         end
         B_SWAIT: begin
            if (srsp.done) state_in = B_EMIT;
         end
         B_EMIT: begin
            if (slot_free) begin
               emit_load = 1'b1;
               face_in   = face_ff + 1'b1;
               state_in  = B_FSEL;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   // Neighbour across the selected face, then the in-plane grid offset.
   always_comb begin
      rd_x = {1'b0, cx_ff};
      rd_y = {1'b0, cy_ff};
      rd_z = {1'b0, cz_ff};
      unique case (sel_face)
         FACE_FRONT:  rd_z = rd_z + 1'b1;
         FACE_BACK:   rd_z = rd_z - 1'b1;
         FACE_RIGHT:  rd_x = rd_x + 1'b1;
         FACE_LEFT:   rd_x = rd_x - 1'b1;
         FACE_BOTTOM: rd_y = rd_y - 1'b1;
         FACE_TOP:    rd_y = rd_y + 1'b1;
         default: ;
      endcase
      if (sel_face == FACE_BOTTOM || sel_face == FACE_TOP) begin
         rd_x = rd_x + CW'(sel_pi) - 1'b1;
      end else begin
         rd_y = rd_y + CW'(sel_pi) - 1'b1;
      end
      if (sel_face == FACE_FRONT || sel_face == FACE_BACK) begin
         rd_x = rd_x + CW'(sel_qi) - 1'b1;
      end else begin
         rd_z = rd_z + CW'(sel_qi) - 1'b1;
      end
      wr_addr = cell_addr({1'b0, cmd.x}, {1'b0, cmd.y}, {1'b0, cmd.z});
      rd_addr = (state_ff == B_IDLE) ? wr_addr : cell_addr(rd_x, rd_y, rd_z);
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= {cmd.btype, cmd.light};
      rd_data_ff <= mem[rd_addr];
   end

   // Corner sums over the 3x3 light grid in front of the face.
   always_comb begin
      sreq.start = scale_start;
      ccode      = corner_code(face_ff);
      sreq.nl    = grid_ff[4];
      for (int k = 0; k < NUM_CORNERS; k++) begin
         sreq.sum4[k] = SUM_W'(grid_ff[4])
            + SUM_W'(grid_ff[ccode[2*k+1] ? 4'd1 : 4'd7])
            + SUM_W'(grid_ff[ccode[2*k] ? 4'd3 : 4'd5])
            + SUM_W'(grid_ff[4'((ccode[2*k+1] ? 0 : 6) + (ccode[2*k] ? 0 : 2))]);
      end
   end

   always_comb begin
      lit_sum = '0;
      for (int k = 0; k < NUM_CORNERS; k++) begin
         lit_sel[k] = (type_ff == TYPE_EMITTER) ? LIGHT_FULL : srsp.lit[k];
         lit_sum    = lit_sum + SUM_W'(lit_sel[k]);
      end
      above_mask = ~((NUM_FACES'(2) << face_ff) - NUM_FACES'(1));
      tile       = tile_index(type_ff, face_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rd_live_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_live_ff <= issue_live;
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      face_ff    <= face_in;
      cnt_ff     <= cnt_in;
      pi_ff      <= pi_in;
      qi_ff      <= qi_in;
      rd_grid_ff <= issue_grid;
      rd_tag_ff  <= issue_tag;
      if (latch_cell) begin
         cx_ff <= cmd.x;
         cy_ff <= cmd.y;
         cz_ff <= cmd.z;
      end
      if (latch_type) type_ff <= rd_data_ff[CELL_W-1:LIGHT_W];
      if (rd_live_ff && !rd_grid_ff) begin
         mask_ff[rd_tag_ff[FACE_W-1:0]] <= (rd_data_ff[CELL_W-1:LIGHT_W] == TYPE_AIR);
      end
      if (rd_live_ff && rd_grid_ff) grid_ff[rd_tag_ff] <= rd_data_ff[LIGHT_W-1:0];
      if (emit_load) begin
         pos_x_ff    <= POS_W'(cx_ff - 1'b1);
         pos_y_ff    <= POS_W'(cy_ff - 1'b1);
         pos_z_ff    <= POS_W'(cz_ff - 1'b1);
         face_out_ff <= face_ff;
         tex_x_ff    <= tex_x_tbl[tile];
         tex_y_ff    <= tex_y_tbl[tile];
         for (int k = 0; k < NUM_CORNERS; k++) lit_ff[k] <= lit_sel[k];
         centre_ff   <= lit_sum[SUM_W-1:2];
         last_ff     <= ((mask_ff & above_mask) == '0);
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.pos_x        = pos_x_ff;
   assign rsp.pos_y        = pos_y_ff;
   assign rsp.pos_z        = pos_z_ff;
   assign rsp.face         = face_out_ff;
   assign rsp.tex_x        = tex_x_ff;
   assign rsp.tex_y        = tex_y_ff;
   assign rsp.corner_a     = lit_ff[0];
   assign rsp.corner_b     = lit_ff[1];
   assign rsp.corner_c     = lit_ff[2];
   assign rsp.corner_d     = lit_ff[3];
   assign rsp.centre_light = centre_ff;
   assign rsp.last_face    = last_ff;

endmodule
`default_nettype wire

>>> rtl/core/voxel_face_cull_light_mesher.sv
// Voxel face culling mesher with smooth corner lighting, top level.
//
// Requests arrive on req_chan. A write request (func 0) stores one cell of the
// padded volume; a mesh request (func 1) on an interior solid cell yields one
// face record on rsp_chan for every face whose neighbour is air, in the order
// front, back, right, left, bottom, top, with last_face on the final record.
// Requests that name no valid cell are dropped at once.
// Requests pass through a two-entry queue, so req_chan keeps taking items, until
// the queue is full, while a mesh request is worked on or a record waits on a
// stalled rsp_chan. A write is stored as it leaves the head of the queue. A mesh
// request first reads the cell and its six neighbours, then steps through the
// faces; for each emitted face it makes nine reads of the volume memory and a
// nine-step divider pass, both of which a light emitter skips. The volume memory
// has a single read port and the dividers are bit-serial. min_light and max_light
// are written through the csr_ port; the user is to write them only while idle,
// the block itself does not enforce it. Reset clears the queue, the sequencer
// and the output register and sets min_light to 0 and max_light to 15; the
// volume contents are undefined. While rsp_chan is stalled the pending record
// holds and the sequencer waits before it emits the next record.
`timescale 1ns / 1ps
`default_nettype none
module voxel_face_cull_light_mesher
   import vfcl_pkg::*;
#(
   parameter int CHUNK_EDGE = CHUNK_EDGE_DEF,
   parameter int TILE_SIZE  = TILE_SIZE_DEF,
   parameter int ATLAS_SIZE = ATLAS_SIZE_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   vfcl_req_if.sink                req_chan,
   vfcl_rsp_if.source              rsp_chan,
   input  wire logic               csr_we,
   input  wire logic [0:0]         csr_index,
   input  wire logic [LIGHT_W-1:0] csr_wdata
);

   logic [LIGHT_W-1:0] min_light_ff, min_light_in;
   logic [LIGHT_W-1:0] max_light_ff, max_light_in;
   logic               cmd_valid, cmd_ready;
   vfcl_cmd_type       cmd;

   always_comb begin
      min_light_in = min_light_ff;
      max_light_in = max_light_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_LIGHT: min_light_in = csr_wdata;
            CSR_MAX_LIGHT: max_light_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_light_ff <= 8'd0;
         max_light_ff <= 8'd15;
      end else begin
         min_light_ff <= min_light_in;
         max_light_ff <= max_light_in;
      end
   end

   vfcl_front #(.CHUNK_EDGE(CHUNK_EDGE)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_ready (cmd_ready)
   );

   vfcl_back #(
      .CHUNK_EDGE (CHUNK_EDGE),
      .TILE_SIZE  (TILE_SIZE),
      .ATLAS_SIZE (ATLAS_SIZE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_ready (cmd_ready),
      .min_light (min_light_ff),
      .max_light (max_light_ff),
      .rsp       (rsp_chan)
   );

endmodule
`default_nettype wire

>>> rtl/core/vfcl_checker.sv
// Port-level checks of the voxel mesher and their attachment to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "voxel_face_cull_light_mesher_macros.svh"
module vfcl_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_face,
   input wire logic [7:0] rsp_a,
   input wire logic [7:0] rsp_b,
   input wire logic [7:0] rsp_c,
   input wire logic [7:0] rsp_d,
   input wire logic [7:0] rsp_centre
);

   `VFCL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_face) && $stable(rsp_centre))
   `VFCL_ASSERT_NOW(a_face_range, rsp_valid, rsp_face != 3'd6 && rsp_face != 3'd7)
   `VFCL_ASSERT_NOW(a_centre_bound, rsp_valid, (rsp_centre <= rsp_a || rsp_centre <= rsp_b || rsp_centre <= rsp_c || rsp_centre <= rsp_d) && (rsp_centre >= rsp_a || rsp_centre >= rsp_b || rsp_centre >= rsp_c || rsp_centre >= rsp_d))

endmodule

bind voxel_face_cull_light_mesher vfcl_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_face   (rsp_chan.face),
   .rsp_a      (rsp_chan.corner_a),
   .rsp_b      (rsp_chan.corner_b),
   .rsp_c      (rsp_chan.corner_c),
   .rsp_d      (rsp_chan.corner_d),
   .rsp_centre (rsp_chan.centre_light)
);
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench of the voxel face mesher: predicted face records against the block.
`timescale 1ns / 1ps
module testbench;
   import vfcl_pkg::*;

   typedef struct packed {
      logic       func;
      logic [4:0] x;
      logic [4:0] y;
      logic [4:0] z;
      logic [3:0] btype;
      logic [7:0] light;
   } request_type;

   typedef struct packed {
      logic [3:0] px;
      logic [3:0] py;
      logic [3:0] pz;
      logic [2:0] face;
      logic [8:0] tx;
      logic [8:0] ty;
      logic [7:0] ca;
      logic [7:0] cb;
      logic [7:0] cc;
      logic [7:0] cd;
      logic [7:0] centre;
      logic       last;
   } face_record_type;

   localparam int PAD = 18;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [0:0] csr_index = CSR_MIN_LIGHT;
   logic [7:0] csr_wdata = 8'd0;

   vfcl_req_if req_chan();
   vfcl_rsp_if rsp_chan();

   voxel_face_cull_light_mesher dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   logic [11:0] volume [PAD*PAD*PAD];
   bit written [PAD*PAD*PAD];
   logic [7:0] floor_light = 8'd0;
   logic [7:0] full_light = 8'd15;

   request_type pending_requests[$];
   face_record_type expected_faces[$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off = 0;
   int mismatches = 0;
   int faces_seen = 0;
   int requests_sent = 0;
   int idle_cycles = 0;
   bit timed_out = 1'b0;
   bit req_taken = 1'b0;

   function automatic int cell_addr(int x, int y, int z);
      return (x * PAD + y) * PAD + z;
   endfunction

   function automatic logic [11:0] cell_value(int x, int y, int z);
      if (x < 0 || y < 0 || z < 0 || x >= PAD || y >= PAD || z >= PAD)
         return 12'd0;
      return volume[cell_addr(x, y, z)];
   endfunction

   function automatic int light_of(int x, int y, int z);
      logic [11:0] c;
      c = cell_value(x, y, z);
      return c[7:0];
   endfunction

   function automatic int tile_of(int t, int f);
      case (t)
         1: return 2;
         2: return 3;
         3: return (f == 4) ? 2 : ((f == 5) ? 1 : 0);
         4: return 4;
         5: return 5;
         6: return (f >= 4) ? 7 : 6;
         7: return 8;
         8: return 9;
         default: return 0;
      endcase
   endfunction

   function automatic int scale_light(int sum4, int nl);
      int m, a, b, c, r;
      m = (full_light == 0) ? 1 : full_light;
      a = (255 * sum4) / (4 * m);
      b = (255 * nl) / (3 * m);
      c = (255 * floor_light) / m;
      r = a;
      if (b > r) r = b;
      if (c > r) r = c;
      return (r > 255) ? 255 : r;
   endfunction

   task automatic queue_request(input request_type r);
      pending_requests = {pending_requests, r};
   endtask

   task automatic apply_request(input request_type r);
      int x, y, z, t, f, k, nx, ny, nz, nl, s, idx, total;
      int nrm [6][3];
      int ud [6][4][3];
      int vd [6][4][3];
      int lit [4];
      logic [11:0] c;
      face_record_type rec;
      face_record_type faces[$];
      nrm = '{'{0,0,1}, '{0,0,-1}, '{1,0,0}, '{-1,0,0}, '{0,-1,0}, '{0,1,0}};
      ud = '{'{'{0,1,0}, '{0,-1,0}, '{0,-1,0}, '{0,1,0}},
             '{'{0,1,0}, '{0,-1,0}, '{0,-1,0}, '{0,1,0}},
             '{'{0,1,0}, '{0,-1,0}, '{0,-1,0}, '{0,1,0}},
             '{'{0,1,0}, '{0,-1,0}, '{0,-1,0}, '{0,1,0}},
             '{'{1,0,0}, '{-1,0,0}, '{-1,0,0}, '{1,0,0}},
             '{'{-1,0,0}, '{1,0,0}, '{1,0,0}, '{-1,0,0}}};
      vd = '{'{'{-1,0,0}, '{-1,0,0}, '{1,0,0}, '{1,0,0}},
             '{'{1,0,0}, '{1,0,0}, '{-1,0,0}, '{-1,0,0}},
             '{'{0,0,1}, '{0,0,1}, '{0,0,-1}, '{0,0,-1}},
             '{'{0,0,-1}, '{0,0,-1}, '{0,0,1}, '{0,0,1}},
             '{'{0,0,1}, '{0,0,1}, '{0,0,-1}, '{0,0,-1}},
             '{'{0,0,1}, '{0,0,1}, '{0,0,-1}, '{0,0,-1}}};
      x = r.x;
      y = r.y;
      z = r.z;
      if (!r.func) begin
         if (x < PAD && y < PAD && z < PAD) begin
            volume[cell_addr(x, y, z)] = {r.btype, r.light};
            written[cell_addr(x, y, z)] = 1'b1;
         end
         return;
      end
      if (x < 1 || y < 1 || z < 1 || x > 16 || y > 16 || z > 16) return;
      c = cell_value(x, y, z);
      t = c[11:8];
      if (t == 0) return;
      for (f = 0; f < 6; f++) begin
         nx = x + nrm[f][0];
         ny = y + nrm[f][1];
         nz = z + nrm[f][2];
         c = cell_value(nx, ny, nz);
         if (c[11:8] != 0) continue;
         nl = c[7:0];
         for (k = 0; k < 4; k++) begin
            if (t == 4) begin
               lit[k] = 255;
            end else begin
               s = nl + light_of(nx + ud[f][k][0], ny + ud[f][k][1], nz + ud[f][k][2])
                  + light_of(nx + vd[f][k][0], ny + vd[f][k][1], nz + vd[f][k][2])
                  + light_of(nx + ud[f][k][0] + vd[f][k][0], ny + ud[f][k][1] + vd[f][k][1],
                             nz + ud[f][k][2] + vd[f][k][2]);
               lit[k] = scale_light(s, nl);
            end
         end
         total = lit[0] + lit[1] + lit[2] + lit[3];
         idx = tile_of(t, f);
         rec.px = 4'(x - 1);
         rec.py = 4'(y - 1);
         rec.pz = 4'(z - 1);
         rec.face = 3'(f);
         rec.tx = 9'((idx % 32) * 16);
         rec.ty = 9'((idx / 32) * 16);
         rec.ca = 8'(lit[0]);
         rec.cb = 8'(lit[1]);
         rec.cc = 8'(lit[2]);
         rec.cd = 8'(lit[3]);
         rec.centre = 8'(total / 4);
         rec.last = 1'b0;
         faces = {faces, rec};
      end
      if (faces.size() > 0) faces[faces.size()-1].last = 1'b1;
      expected_faces = {expected_faces, faces};
   endtask

   always @(posedge clock) begin
      req_taken <= req_chan.valid && req_chan.ready;
   end

   // Driver: offers queued requests and predicts on each transfer.
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_taken) begin
            apply_request(pending_requests.pop_front());
            requests_sent++;
         end
         if (req_chan.valid && !req_taken) begin
            req_chan.valid <= 1'b1;
         end else if (pending_requests.size() > 0 &&
                      $urandom_range(99) >= send_idle_pct) begin
            req_chan.valid <= 1'b1;
            {req_chan.func, req_chan.cell_x, req_chan.cell_y, req_chan.cell_z,
             req_chan.block_type, req_chan.light_level} <= pending_requests[0];
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Receiver: random idling, or a long hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_off--;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor.
   always @(posedge clock) begin
      face_record_type got, want;
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = {rsp_chan.pos_x, rsp_chan.pos_y, rsp_chan.pos_z, rsp_chan.face,
                   rsp_chan.tex_x, rsp_chan.tex_y, rsp_chan.corner_a, rsp_chan.corner_b,
                   rsp_chan.corner_c, rsp_chan.corner_d, rsp_chan.centre_light,
                   rsp_chan.last_face};
            faces_seen++;
            if (expected_faces.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected face record %h", got);
            end else begin
               want = expected_faces.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Face record mismatch: expected %h, got %h", want, got);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("Watchdog expired with %0d records outstanding.", expected_faces.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic request_type write_req(int x, int y, int z, int t, int l);
      request_type r;
      r.func = 1'b0;
      r.x = 5'(x);
      r.y = 5'(y);
      r.z = 5'(z);
      r.btype = 4'(t);
      r.light = 8'(l);
      return r;
   endfunction

   function automatic request_type mesh_req(int x, int y, int z);
      request_type r;
      r = write_req(x, y, z, $urandom_range(15), $urandom_range(255));
      r.func = 1'b1;
      return r;
   endfunction

   // Meshes only ever touch the cell and the 3x3x3 block around it.
   task automatic fill_block(int x, int y, int z);
      int dx, dy, dz, t;
      for (dx = -1; dx <= 1; dx++)
         for (dy = -1; dy <= 1; dy++)
            for (dz = -1; dz <= 1; dz++)
               if (x+dx >= 0 && y+dy >= 0 && z+dz >= 0 && x+dx < PAD && y+dy < PAD
                   && z+dz < PAD && !written[cell_addr(x+dx, y+dy, z+dz)]) begin
                  t = ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 15);
                  queue_request(write_req(x+dx, y+dy, z+dz, t, $urandom_range(255)));
                  written[cell_addr(x+dx, y+dy, z+dz)] = 1'b1;
               end
   endtask

   task automatic wait_drained();
      wait (pending_requests.size() == 0 && !req_chan.valid && expected_faces.size() == 0);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [7:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      floor_light = (idx == CSR_MIN_LIGHT) ? val : floor_light;
      full_light = (idx == CSR_MAX_LIGHT) ? val : full_light;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Cells are drawn from two small clusters at opposite corners of the volume.
   task automatic random_phase(int n);
      int i, x, y, z, t, base;
      for (i = 0; i < n; i++) begin
         base = ($urandom_range(1) == 0) ? 1 : 15;
         x = base + $urandom_range(1);
         y = base + $urandom_range(1);
         z = base + $urandom_range(1);
         fill_block(x, y, z);
         t = $urandom_range(1, 15);
         if ($urandom_range(3) == 0) t = 4;
         queue_request(write_req(x, y, z, t, $urandom_range(255)));
         queue_request(mesh_req(x, y, z));
         if ($urandom_range(7) == 0)
            queue_request(mesh_req($urandom_range(1) * 17, $urandom_range(31),
                                   $urandom_range(31)));
         if ($urandom_range(7) == 0)
            queue_request(write_req(18 + $urandom_range(13), $urandom_range(31),
                                    $urandom_range(31), $urandom_range(15),
                                    $urandom_range(255)));
         if ($urandom_range(5) == 0) begin
            queue_request(write_req(x, y, z, 0, $urandom_range(255)));
            queue_request(mesh_req(x, y, z));
         end
      end
   endtask

   initial begin
      int t;
      req_chan.valid = 1'b0;
      req_chan.func = 1'b0;
      req_chan.cell_x = '0;
      req_chan.cell_y = '0;
      req_chan.cell_z = '0;
      req_chan.block_type = '0;
      req_chan.light_level = '0;
      rsp_chan.ready = 1'b0;
      foreach (volume[i]) begin
         volume[i] = 12'd0;
         written[i] = 1'b0;
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: corners of the volume, every block type, emitter, air, out of range.
      fill_block(1, 1, 1);
      fill_block(16, 16, 16);
      queue_request(write_req(1, 1, 1, 3, 255));
      queue_request(mesh_req(1, 1, 1));
      queue_request(write_req(16, 16, 16, 4, 0));
      queue_request(mesh_req(16, 16, 16));
      queue_request(mesh_req(0, 5, 5));
      queue_request(mesh_req(17, 17, 17));
      queue_request(mesh_req(31, 31, 31));
      queue_request(write_req(31, 31, 31, 15, 255));
      queue_request(write_req(16, 16, 16, 0, 128));
      queue_request(mesh_req(16, 16, 16));
      for (t = 1; t <= 15; t++) begin
         queue_request(write_req(1, 1, 1, t, 85));
         queue_request(mesh_req(1, 1, 1));
      end
      send_idle_pct = 16;
      recv_idle_pct = 60;
      wait_drained();

      write_csr(CSR_MAX_LIGHT, 8'd1);
      write_csr(CSR_MIN_LIGHT, 8'd0);
      random_phase(14);
      wait_drained();
      write_csr(CSR_MAX_LIGHT, 8'd255);
      write_csr(CSR_MIN_LIGHT, 8'd255);
      random_phase(14);
      wait_drained();

      send_idle_pct = 60;
      recv_idle_pct = 16;
      write_csr(CSR_MAX_LIGHT, 8'd0);
      write_csr(CSR_MIN_LIGHT, 8'd3);
      random_phase(14);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(CSR_MAX_LIGHT, 8'd15);
      write_csr(CSR_MIN_LIGHT, 8'd20);
      hold_off = 400;
      random_phase(12);
      wait_drained();
      write_csr(CSR_MAX_LIGHT, 8'd64);
      write_csr(CSR_MIN_LIGHT, 8'd7);
      random_phase(12);
      wait_drained();

      $display("Sent %0d requests and checked %0d face records over six light settings.",
               requests_sent, faces_seen);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
